// ===== hdl/rnfe_pkg.sv =====
// Shared types and constants for the RSSI noise floor estimator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rnfe_pkg;

  localparam int CMD_W   = 2;
  localparam int RSSI_W  = 9;
  localparam int THR_W   = 7;
  localparam int FLOOR_W = 9;
  localparam int SUM_W   = 15;
  // wide enough for rssi against floor plus margin or threshold
  localparam int CMP_W   = 11;

  localparam int ACCEPT_MARGIN = 14;
  localparam int FLOOR_MIN     = -120;

  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
  localparam logic [CMD_W-1:0] CMD_AGC     = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [RSSI_W-1:0] rssi;
    logic                     rx_mode;
    logic                     arriving;
    logic                     irq;
  } in_item_t;

  typedef struct packed {
    logic signed [FLOOR_W-1:0] floor_dbm;
    logic                      channel_busy;
    logic                      sampling_done;
    logic                      agc_reset_done;
  } result_t;

endpackage

// ===== hdl/rnfe_in_reg.sv =====
// Input register stage: captures one input word and holds it until the core takes it.
// Depends on rnfe_pkg.
`timescale 1ns / 1ps

module rnfe_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rnfe_pkg::in_item_t in_item,
  input  logic               take,
  output logic               item_valid,
  output rnfe_pkg::in_item_t item
);
  import rnfe_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     load;

  assign in_stall  = valid_r && !take;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== hdl/rnfe_floor_div.sv =====
// Floor candidate: sample sum divided by the run length, truncated toward zero,
// clamped below. Reciprocal multiply, exact for all 15-bit sums. Depends on rnfe_pkg.
`timescale 1ns / 1ps

module rnfe_floor_div #(
  parameter int RUN_LENGTH = 64
) (
  input  logic signed [rnfe_pkg::SUM_W-1:0]   sum,
  output logic signed [rnfe_pkg::FLOOR_W-1:0] floor_val
);
  import rnfe_pkg::*;

  localparam int DIV_SHIFT = SUM_W + $clog2(RUN_LENGTH);
  localparam int PROD_W    = SUM_W + DIV_SHIFT;
  localparam logic [DIV_SHIFT-1:0] DIV_MULT =
    DIV_SHIFT'(((64'd1 << DIV_SHIFT) + 64'(RUN_LENGTH) - 64'd1) / 64'(RUN_LENGTH));

  logic [SUM_W-1:0]        mag;
  logic [PROD_W-1:0]       prod;
  logic [SUM_W-1:0]        quot;
  logic signed [SUM_W:0]   quot_s;
  logic signed [SUM_W:0]   signed_q;
  logic signed [SUM_W:0]   clamped;

  // magnitude of the most negative sum still fits unsigned
  assign mag      = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign prod     = PROD_W'(mag) * PROD_W'(DIV_MULT);
  assign quot     = prod[PROD_W-1:DIV_SHIFT];
  assign quot_s   = {1'b0, quot};
  assign signed_q = sum[SUM_W-1] ? -quot_s : quot_s;
  assign clamped  = (signed_q < FLOOR_MIN) ? (SUM_W+1)'(FLOOR_MIN) : signed_q;
  assign floor_val = clamped[FLOOR_W-1:0];

endmodule

// ===== hdl/rnfe_core.sv =====
// Estimator core: floor, count and sum state, per-word update and the result register.
// Depends on rnfe_pkg and rnfe_floor_div.
`timescale 1ns / 1ps

module rnfe_core #(
  parameter int RUN_LENGTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              item_valid,
  input  rnfe_pkg::in_item_t                item,
  output logic                              take,
  input  logic signed [rnfe_pkg::THR_W-1:0] threshold,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rnfe_pkg::result_t                 result
);
  import rnfe_pkg::*;

  localparam int CNT_W = $clog2(RUN_LENGTH + 1);
  localparam logic [CNT_W-1:0] RUN_END = CNT_W'(RUN_LENGTH);

  logic signed [FLOOR_W-1:0] floor_r, floor_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic                      out_valid_r, out_valid_nxt;
  result_t                   result_r, result_nxt;

  logic signed [FLOOR_W-1:0] div_floor;
  logic signed [RSSI_W-1:0]  rssi;
  logic signed [CMP_W-1:0]   rssi_ext;
  logic signed [CMP_W-1:0]   accept_lim;
  logic signed [CMP_W-1:0]   busy_lim;
  logic                      run_full;
  logic                      agc_done;
  logic                      out_free;

  rnfe_floor_div #(
    .RUN_LENGTH(RUN_LENGTH)
  ) u_div (
    .sum      (sum_r),
    .floor_val(div_floor)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign take     = item_valid && out_free;

  assign rssi       = item.rssi;
  assign rssi_ext   = CMP_W'(rssi);
  assign accept_lim = CMP_W'(floor_r) + CMP_W'(ACCEPT_MARGIN);
  assign run_full   = (count_r == RUN_END);

  always_comb begin
    floor_nxt = floor_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    agc_done  = 1'b0;
    case (item.cmd)
      CMD_TICK: begin
        if (item.rx_mode && !run_full) begin
          if (!item.arriving && (rssi_ext < accept_lim)) begin
            count_nxt = count_r + CNT_W'(1);
            sum_nxt   = sum_r + SUM_W'(rssi);
          end
        end else if (run_full && (sum_r != '0)) begin
          floor_nxt = div_floor;
          sum_nxt   = '0;
        end
      end
      CMD_RESTART: begin
        if (run_full) begin
          count_nxt = '0;
          sum_nxt   = '0;
        end
      end
      CMD_AGC: begin
        if (!item.irq && !item.arriving) begin
          floor_nxt = '0;
          count_nxt = '0;
          sum_nxt   = '0;
          agc_done  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // busy is judged against the floor as it stands after this word
  assign busy_lim = CMP_W'(floor_nxt) + CMP_W'(threshold);

  always_comb begin
    result_nxt.floor_dbm      = floor_nxt;
    result_nxt.channel_busy   = (threshold != '0) && (rssi_ext > busy_lim);
    result_nxt.sampling_done  = (count_nxt == RUN_END);
    result_nxt.agc_reset_done = agc_done;
  end

  assign out_valid_nxt = take ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r     <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        floor_r <= floor_nxt;
        count_r <= count_nxt;
        sum_r   <= sum_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

// ===== hdl/rssi_noise_floor_estimator.sv =====
// RSSI noise floor estimator, top level.
// Input channel (in_valid / in_stall): one word per command: cmd, rssi and the
//   radio status bits. A word is taken when in_valid is high and in_stall low.
// Result channel (out_valid / out_stall): one result word per input word, in
//   order: floor_dbm, channel_busy, sampling_done, agc_reset_done.
// Config channel (cfg_valid / cfg_ready): writes the signed interference
//   threshold; cfg_ready is always high. Write only while the block is idle.
// Path: a taken word passes the input register, then the result register, before
//   its result shows on out_valid.
// Throughput: one word per cycle unless out_stall holds a result; floor, count
//   and sum are updated combinationally between the input and result registers,
//   with the divide by RUN_LENGTH done as one reciprocal multiply on the stored sum.
// Stall: while out_stall holds a result, one more word is kept in the input
//   register; after that in_stall rises until the result is taken.
// Reset (rst_n, synchronous): clears floor, count, sum and threshold and
//   empties both registers; the block accepts a word as soon as rst_n is released.
// Depends on rnfe_pkg, rnfe_in_reg, rnfe_core.
`timescale 1ns / 1ps

module rssi_noise_floor_estimator #(
  parameter int RUN_LENGTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rnfe_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [rnfe_pkg::RSSI_W-1:0]  in_rssi,
  input  logic                                in_in_receive_mode,
  input  logic                                in_packet_arriving,
  input  logic                                in_irq_pending,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rnfe_pkg::FLOOR_W-1:0] out_floor_dbm,
  output logic                                out_channel_busy,
  output logic                                out_sampling_done,
  output logic                                out_agc_reset_done,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic signed [rnfe_pkg::THR_W-1:0]   cfg_data
);
  import rnfe_pkg::*;

  logic signed [THR_W-1:0] threshold_r;
  in_item_t                in_item;
  in_item_t                held_item;
  logic                    held_valid;
  logic                    take;
  result_t                 result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      threshold_r <= cfg_data;
    end
  end

  always_comb begin
    in_item.cmd      = in_cmd;
    in_item.rssi     = in_rssi;
    in_item.rx_mode  = in_in_receive_mode;
    in_item.arriving = in_packet_arriving;
    in_item.irq      = in_irq_pending;
  end

  rnfe_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .take      (take),
    .item_valid(held_valid),
    .item      (held_item)
  );

  rnfe_core #(
    .RUN_LENGTH(RUN_LENGTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(held_valid),
    .item      (held_item),
    .take      (take),
    .threshold (threshold_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign out_floor_dbm      = result.floor_dbm;
  assign out_channel_busy   = result.channel_busy;
  assign out_sampling_done  = result.sampling_done;
  assign out_agc_reset_done = result.agc_reset_done;

endmodule
